// ===== sv/nidt_pkg.sv =====
// shared types and codes for the node id assignment table
package nidt_pkg;

    localparam logic [2:0] REQ_ASSIGN   = 3'd0;
    localparam logic [2:0] REQ_PRELOAD  = 3'd1;
    localparam logic [2:0] REQ_ONLINE   = 3'd2;
    localparam logic [2:0] REQ_OFFLINE  = 3'd3;
    localparam logic [2:0] REQ_FORGET   = 3'd4;
    localparam logic [2:0] REQ_REASSIGN = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_BUSY      = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic [1:0] MODE_OFFLINE = 2'd0;
    localparam logic [1:0] MODE_PREOP   = 2'd1;
    localparam logic [1:0] MODE_OPER    = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [6:0]  node_id;
        logic [6:0]  new_node_id;
        logic [63:0] uid;
        logic [3:0]  uid_len;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] assigned_id;
        logic       is_new;
        logic       map_upd;
        logic [1:0] node_mode;
    } out_item_t;

endpackage

// ===== sv/node_id_assignment_table.sv =====
// top level: request sequencer plus a result register
// request flow: assign runs a node scan, a map search and a map update, one memory read per cycle;
//   reassign moves the slot and makes up to three map passes, preload and forget make one map pass,
//   online and offline update the node slot, rejected requests go straight to the result
// throughput: one request at a time, the next beat is taken in the cycle after the result moves on
// reset: synchronous active-low aresetn clears the used flags, no clearing pass, ready right after
module node_id_assignment_table #(
    parameter int NODE_SLOTS = 128,
    parameter int UID_BYTES = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  nidt_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output nidt_pkg::out_item_t m_item
);

    logic                res_valid;
    logic                res_ready;
    nidt_pkg::out_item_t res;

    logic                m_valid_reg;
    nidt_pkg::out_item_t m_item_reg;

    // sequencer owns both memories and the used flags
    nidt_ctrl #(
        .NODE_SLOTS (NODE_SLOTS),
        .UID_BYTES  (UID_BYTES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (s_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // result register frees the sequencer for the next request beat
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                m_valid_reg <= 1'b1;
                m_item_reg  <= res;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ===== sv/nidt_ram.sv =====
// generic simple dual port ram with registered read
module nidt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/nidt_ctrl.sv =====
// request sequencer with node and map memories and scan pipeline
module nidt_ctrl #(
    parameter int NODE_SLOTS = 128,
    parameter int UID_BYTES = 8,
    localparam int SW = $clog2(NODE_SLOTS),
    localparam int UW = 8 * UID_BYTES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  nidt_pkg::in_item_t   req,
    output logic                 res_valid,
    input  logic                 res_ready,
    output nidt_pkg::out_item_t  res
);

    localparam logic [SW-1:0] LAST = SW'(NODE_SLOTS - 1);
    localparam int SLOT_W = UW + 3;
    localparam int MAP_W = SW + UW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SLOT_RMW,
        S_SLOT_SCAN,
        S_MAP_FIND,
        S_MAP_INIT,
        S_MAP_PASS,
        S_NEXT,
        S_DONE
    } state_t;

    state_t              state_reg;
    nidt_pkg::in_item_t  req_reg;
    logic [UW-1:0]       uid_reg;
    logic [NODE_SLOTS-1:0] slot_used_reg;
    logic [NODE_SLOTS-1:0] map_used_reg;

    logic [SW-1:0] scan_idx_reg;
    logic          iss_reg;
    logic          chk_valid_reg;
    logic [SW-1:0] chk_idx_reg;
    logic          free_found_reg;
    logic [SW-1:0] free_idx_reg;

    logic          mset_reg;
    logic [SW-1:0] mnode_reg;
    logic [UW-1:0] muid_reg;
    logic [1:0]    step_reg;
    logic          sk_reg;
    logic [UW-1:0] su_reg;

    logic [2:0]    st_reg;
    logic [SW-1:0] asg_reg;
    logic          new_reg;
    logic          chg_reg;
    logic [1:0]    mode_reg;

    logic              slot_we_reg;
    logic [SW-1:0]     slot_waddr_reg;
    logic [SLOT_W-1:0] slot_wdata_reg;
    logic              map_we_reg;
    logic [SW-1:0]     map_waddr_reg;
    logic [MAP_W-1:0]  map_wdata_reg;

    logic [SW-1:0]     slot_raddr;
    logic [SLOT_W-1:0] slot_rdata;
    logic [MAP_W-1:0]  map_rdata;

    logic          rd_known;
    logic [1:0]    rd_mode;
    logic [UW-1:0] rd_suid;
    logic [SW-1:0] rd_node;
    logic [UW-1:0] rd_muid;

    logic [UW-1:0] uid_cap;
    logic          ulen_ok;
    logic          nid_ok;
    logic          nnid_ok;
    logic [SW-1:0] nid_idx;
    logic [SW-1:0] nnid_idx;
    logic          scanning;
    logic          chk_last;
    logic          free_any;
    logic [SW-1:0] free_sel;
    logic          map_node_ok;
    logic          pass_end_next;

    nidt_ram #(.WIDTH(SLOT_W), .DEPTH(NODE_SLOTS)) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we_reg),
        .waddr (slot_waddr_reg),
        .wdata (slot_wdata_reg),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    nidt_ram #(.WIDTH(MAP_W), .DEPTH(NODE_SLOTS)) u_map_ram (
        .aclk  (aclk),
        .we    (map_we_reg),
        .waddr (map_waddr_reg),
        .wdata (map_wdata_reg),
        .raddr (scan_idx_reg),
        .rdata (map_rdata)
    );

    // capture: assign uses only uid_len bytes, others keep UID_BYTES bytes
    always_comb begin
        for (int b = 0; b < UID_BYTES; b++) begin
            if (req.req_type != nidt_pkg::REQ_ASSIGN || 4'(b) < req.uid_len) begin
                uid_cap[8*b +: 8] = req.uid[8*b +: 8];
            end else begin
                uid_cap[8*b +: 8] = 8'd0;
            end
        end
    end

    assign rd_known = slot_rdata[UW+2];
    assign rd_mode  = slot_rdata[UW+1:UW];
    assign rd_suid  = slot_rdata[UW-1:0];
    assign rd_node  = map_rdata[MAP_W-1:UW];
    assign rd_muid  = map_rdata[UW-1:0];

    assign ulen_ok  = (req_reg.uid_len != 4'd0) && (32'(req_reg.uid_len) <= UID_BYTES);
    assign nid_ok   = (req_reg.node_id != 7'd0) && (32'(req_reg.node_id) < NODE_SLOTS);
    assign nnid_ok  = (req_reg.new_node_id != 7'd0) && (32'(req_reg.new_node_id) < NODE_SLOTS);
    assign nid_idx  = SW'(req_reg.node_id);
    assign nnid_idx = SW'(req_reg.new_node_id);

    assign slot_raddr = (state_reg == S_DECODE) ? nid_idx : scan_idx_reg;

    assign scanning = (state_reg == S_SLOT_SCAN) || (state_reg == S_MAP_FIND)
                   || (state_reg == S_MAP_PASS);
    assign chk_last = (chk_idx_reg == LAST);
    // first free map entry including the one under check
    assign free_any = free_found_reg || !map_used_reg[chk_idx_reg];
    assign free_sel = free_found_reg ? free_idx_reg : chk_idx_reg;
    assign map_node_ok = (rd_node != '0) && (32'(rd_node) < NODE_SLOTS);
    assign pass_end_next = (req_reg.req_type == nidt_pkg::REQ_REASSIGN) && (step_reg != 2'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            slot_used_reg <= '0;
            map_used_reg  <= '0;
            iss_reg       <= 1'b0;
            chk_valid_reg <= 1'b0;
            slot_we_reg   <= 1'b0;
            map_we_reg    <= 1'b0;
        end else begin
            slot_we_reg <= 1'b0;
            map_we_reg  <= 1'b0;

            // read pipeline shared by all scans
            if (scanning) begin
                chk_valid_reg <= iss_reg;
                chk_idx_reg   <= scan_idx_reg;
                if (iss_reg) begin
                    if (scan_idx_reg == LAST) begin
                        iss_reg <= 1'b0;
                    end else begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
            end

            case (state_reg)
                S_IDLE: begin
                    if (req_valid) begin
                        req_reg  <= req;
                        uid_reg  <= uid_cap;
                        st_reg   <= nidt_pkg::ST_OK;
                        asg_reg  <= '0;
                        new_reg  <= 1'b0;
                        chg_reg  <= 1'b0;
                        mode_reg <= nidt_pkg::MODE_OFFLINE;
                        state_reg <= S_DECODE;
                    end
                end

                S_DECODE: begin
                    state_reg <= S_DONE;
                    case (req_reg.req_type)
                        nidt_pkg::REQ_ASSIGN: begin
                            if (!ulen_ok) begin
                                st_reg <= nidt_pkg::ST_INVALID;
                            end else begin
                                scan_idx_reg   <= SW'(1);
                                iss_reg        <= 1'b1;
                                chk_valid_reg  <= 1'b0;
                                free_found_reg <= 1'b0;
                                state_reg      <= S_SLOT_SCAN;
                            end
                        end
                        nidt_pkg::REQ_PRELOAD: begin
                            if (!nid_ok) begin
                                st_reg <= nidt_pkg::ST_INVALID;
                            end else begin
                                mset_reg  <= 1'b1;
                                mnode_reg <= nid_idx;
                                muid_reg  <= uid_reg;
                                state_reg <= S_MAP_INIT;
                            end
                        end
                        nidt_pkg::REQ_ONLINE: begin
                            if (!nid_ok) begin
                                st_reg <= nidt_pkg::ST_INVALID;
                            end else if (!slot_used_reg[nid_idx]) begin
                                slot_we_reg    <= 1'b1;
                                slot_waddr_reg <= nid_idx;
                                slot_wdata_reg <= {1'b0, nidt_pkg::MODE_OPER, UW'(0)};
                                slot_used_reg[nid_idx] <= 1'b1;
                                new_reg  <= 1'b1;
                                mode_reg <= nidt_pkg::MODE_OPER;
                            end else begin
                                state_reg <= S_SLOT_RMW;
                            end
                        end
                        nidt_pkg::REQ_OFFLINE: begin
                            if (req_reg.node_id == 7'd0) begin
                                st_reg <= nidt_pkg::ST_INVALID;
                            end else if (!nid_ok || !slot_used_reg[nid_idx]) begin
                                st_reg <= nidt_pkg::ST_NOT_FOUND;
                            end else begin
                                state_reg <= S_SLOT_RMW;
                            end
                        end
                        nidt_pkg::REQ_FORGET: begin
                            if (req_reg.node_id == 7'd0) begin
                                st_reg <= nidt_pkg::ST_INVALID;
                            end else begin
                                if (!nid_ok || !slot_used_reg[nid_idx]) begin
                                    st_reg <= nidt_pkg::ST_NOT_FOUND;
                                end else begin
                                    slot_used_reg[nid_idx] <= 1'b0;
                                end
                                // numbers past the table have no map entry
                                if (nid_ok) begin
                                    mset_reg  <= 1'b0;
                                    mnode_reg <= nid_idx;
                                    state_reg <= S_MAP_INIT;
                                end
                            end
                        end
                        nidt_pkg::REQ_REASSIGN: begin
                            if (!nid_ok || !nnid_ok) begin
                                st_reg <= nidt_pkg::ST_INVALID;
                            end else if (!slot_used_reg[nid_idx]) begin
                                st_reg <= nidt_pkg::ST_NOT_FOUND;
                            end else if (nid_idx != nnid_idx && slot_used_reg[nnid_idx]) begin
                                st_reg <= nidt_pkg::ST_BUSY;
                            end else begin
                                state_reg <= S_SLOT_RMW;
                            end
                        end
                        default: begin
                            st_reg <= nidt_pkg::ST_INVALID;
                        end
                    endcase
                end

                S_SLOT_RMW: begin
                    state_reg <= S_DONE;
                    case (req_reg.req_type)
                        nidt_pkg::REQ_ONLINE: begin
                            slot_we_reg    <= 1'b1;
                            slot_waddr_reg <= nid_idx;
                            slot_wdata_reg <= {rd_known, nidt_pkg::MODE_OPER, rd_suid};
                            mode_reg       <= nidt_pkg::MODE_OPER;
                        end
                        nidt_pkg::REQ_OFFLINE: begin
                            slot_we_reg    <= 1'b1;
                            slot_waddr_reg <= nid_idx;
                            slot_wdata_reg <= {rd_known, nidt_pkg::MODE_OFFLINE, rd_suid};
                            mode_reg       <= nidt_pkg::MODE_OFFLINE;
                        end
                        nidt_pkg::REQ_REASSIGN: begin
                            if (nid_idx == nnid_idx) begin
                                mode_reg <= rd_mode;
                            end else begin
                                slot_we_reg    <= 1'b1;
                                slot_waddr_reg <= nnid_idx;
                                slot_wdata_reg <= {rd_known, nidt_pkg::MODE_PREOP, rd_suid};
                                slot_used_reg[nid_idx]  <= 1'b0;
                                slot_used_reg[nnid_idx] <= 1'b1;
                                mode_reg  <= nidt_pkg::MODE_PREOP;
                                sk_reg    <= rd_known;
                                su_reg    <= rd_suid;
                                step_reg  <= 2'd0;
                                mset_reg  <= 1'b0;
                                mnode_reg <= nid_idx;
                                state_reg <= S_MAP_INIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                S_SLOT_SCAN: begin
                    state_reg <= S_SLOT_SCAN;
                    if (chk_valid_reg) begin
                        if (!slot_used_reg[chk_idx_reg] && !free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= chk_idx_reg;
                        end
                        if (slot_used_reg[chk_idx_reg] && rd_suid == uid_reg) begin
                            asg_reg   <= chk_idx_reg;
                            mode_reg  <= rd_mode;
                            mset_reg  <= 1'b1;
                            mnode_reg <= chk_idx_reg;
                            muid_reg  <= uid_reg;
                            state_reg <= S_MAP_INIT;
                        end else if (chk_last) begin
                            scan_idx_reg  <= '0;
                            iss_reg       <= 1'b1;
                            chk_valid_reg <= 1'b0;
                            state_reg     <= S_MAP_FIND;
                        end
                    end
                end

                S_MAP_FIND: begin
                    state_reg <= S_MAP_FIND;
                    if (chk_valid_reg) begin
                        if (map_used_reg[chk_idx_reg] && rd_muid == uid_reg && map_node_ok) begin
                            // remembered node, claimed without counting as new
                            slot_we_reg    <= 1'b1;
                            slot_waddr_reg <= rd_node;
                            slot_wdata_reg <= {1'b1, nidt_pkg::MODE_PREOP, uid_reg};
                            slot_used_reg[rd_node] <= 1'b1;
                            asg_reg   <= rd_node;
                            mode_reg  <= nidt_pkg::MODE_PREOP;
                            mset_reg  <= 1'b1;
                            mnode_reg <= rd_node;
                            muid_reg  <= uid_reg;
                            state_reg <= S_MAP_INIT;
                        end else if ((map_used_reg[chk_idx_reg] && rd_muid == uid_reg)
                                     || chk_last) begin
                            if (free_found_reg) begin
                                slot_we_reg    <= 1'b1;
                                slot_waddr_reg <= free_idx_reg;
                                slot_wdata_reg <= {1'b1, nidt_pkg::MODE_PREOP, uid_reg};
                                slot_used_reg[free_idx_reg] <= 1'b1;
                                asg_reg   <= free_idx_reg;
                                new_reg   <= 1'b1;
                                mode_reg  <= nidt_pkg::MODE_PREOP;
                                mset_reg  <= 1'b1;
                                mnode_reg <= free_idx_reg;
                                muid_reg  <= uid_reg;
                                state_reg <= S_MAP_INIT;
                            end else begin
                                st_reg    <= nidt_pkg::ST_FULL;
                                state_reg <= S_DONE;
                            end
                        end
                    end
                end

                S_MAP_INIT: begin
                    scan_idx_reg   <= '0;
                    iss_reg        <= 1'b1;
                    chk_valid_reg  <= 1'b0;
                    free_found_reg <= 1'b0;
                    state_reg      <= S_MAP_PASS;
                end

                S_MAP_PASS: begin
                    state_reg <= S_MAP_PASS;
                    if (chk_valid_reg) begin
                        if (!map_used_reg[chk_idx_reg] && !free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= chk_idx_reg;
                        end
                        if (map_used_reg[chk_idx_reg] && rd_node == mnode_reg) begin
                            if (mset_reg) begin
                                if (rd_muid != muid_reg) begin
                                    map_we_reg    <= 1'b1;
                                    map_waddr_reg <= chk_idx_reg;
                                    map_wdata_reg <= {mnode_reg, muid_reg};
                                    chg_reg       <= 1'b1;
                                end
                            end else begin
                                map_used_reg[chk_idx_reg] <= 1'b0;
                                chg_reg <= 1'b1;
                            end
                            state_reg <= pass_end_next ? S_NEXT : S_DONE;
                        end else if (chk_last) begin
                            // map full means nothing is remembered
                            if (mset_reg && free_any) begin
                                map_we_reg    <= 1'b1;
                                map_waddr_reg <= free_sel;
                                map_wdata_reg <= {mnode_reg, muid_reg};
                                map_used_reg[free_sel] <= 1'b1;
                                chg_reg <= 1'b1;
                            end
                            state_reg <= pass_end_next ? S_NEXT : S_DONE;
                        end
                    end
                end

                S_NEXT: begin
                    if (step_reg == 2'd0) begin
                        step_reg  <= 2'd1;
                        mset_reg  <= 1'b0;
                        mnode_reg <= nnid_idx;
                        state_reg <= S_MAP_INIT;
                    end else if (sk_reg) begin
                        step_reg  <= 2'd2;
                        mset_reg  <= 1'b1;
                        mnode_reg <= nnid_idx;
                        muid_reg  <= su_reg;
                        state_reg <= S_MAP_INIT;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end

                S_DONE: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    // errors report no node, no mode and nothing new
    always_comb begin
        res.status  = st_reg;
        res.map_upd = chg_reg;
        if (st_reg == nidt_pkg::ST_OK) begin
            res.assigned_id = 7'(asg_reg);
            res.is_new      = new_reg;
            res.node_mode   = mode_reg;
        end else begin
            res.assigned_id = 7'd0;
            res.is_new      = 1'b0;
            res.node_mode   = nidt_pkg::MODE_OFFLINE;
        end
    end

endmodule
